/* rtl/core/ran_pkg.sv */
// Package for the rational adder: payload structs, status codes, sequencer states.
// Depends on nothing; used by every file in rtl/core.
package ran_pkg;

   localparam int WIDTH = 32;
   localparam int PW    = 64;   // width of cross products and GCD operands
   localparam int NCELL = 8;    // multiplier cells, 4 bits of the multiplier each
   localparam int DIGW  = PW / NCELL;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZDEN = 2'd1,
      STATUS_OVF  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_GCD_START, ST_GCD, ST_DIVN_START, ST_DIVN,
      ST_DIVD_START, ST_DIVD, ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sum_num;
      logic [30:0]        sum_den;
      logic               is_equal;
      logic               is_less;
      logic               a_nonzero;
      logic [1:0]         status;
   } rsp_type;

   // Control from the sequencer to the shared divider.
   typedef struct packed {
      logic start;
      logic [PW-1:0] dividend;
      logic [PW-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic [PW-1:0] quotient;
      logic [PW-1:0] remainder;
   } div_res_type;

endpackage

/* rtl/core/ran_mul_cell.sv */
// One cell of the systolic multiplier chain: adds its partial product and passes on.
// Depends on ran_pkg.
module ran_mul_cell (
   input  logic                      clock,
   input  logic [ran_pkg::PW-1:0]    mcand_in,
   input  logic [ran_pkg::PW/2-1:0]  mplier_in,
   input  logic [ran_pkg::PW-1:0]    acc_in,
   input  logic [2:0]                idx_in,
   output logic [ran_pkg::PW-1:0]    mcand_out,
   output logic [ran_pkg::PW/2-1:0]  mplier_out,
   output logic [ran_pkg::PW-1:0]    acc_out
);
   logic [ran_pkg::PW-1:0]   acc_ff, mcand_ff;
   logic [ran_pkg::PW/2-1:0] mplier_ff;
   logic [3:0]               dig;
   logic [ran_pkg::PW-1:0]   part;

   always_comb begin
      dig  = mplier_in[{idx_in, 2'b00} +: 4];
      part = (mcand_in * {{(ran_pkg::PW-4){1'b0}}, dig}) << {idx_in, 2'b00};
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in + part;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign acc_out    = acc_ff;
   assign mcand_out  = mcand_ff;
   assign mplier_out = mplier_ff;
endmodule

/* rtl/core/ran_mul_chain.sv */
// Chain of eight registered multiplier cells giving a 32x32 product.
// Depends on ran_pkg and ran_mul_cell.
module ran_mul_chain (
   input  logic                     clock,
   input  logic [ran_pkg::PW/2-1:0] x,
   input  logic [ran_pkg::PW/2-1:0] y,
   output logic [ran_pkg::PW-1:0]   prod
);
   logic [ran_pkg::PW-1:0]   mc [0:ran_pkg::NCELL];
   logic [ran_pkg::PW/2-1:0] mp [0:ran_pkg::NCELL];
   logic [ran_pkg::PW-1:0]   ac [0:ran_pkg::NCELL];

   assign mc[0] = {{(ran_pkg::PW/2){1'b0}}, x};
   assign mp[0] = y;
   assign ac[0] = '0;

   for (genvar i = 0; i < ran_pkg::NCELL; i++) begin : g_cell
      ran_mul_cell u_cell (
         .clock(clock), .mcand_in(mc[i]), .mplier_in(mp[i]), .acc_in(ac[i]),
         .idx_in(3'(i)), .mcand_out(mc[i+1]), .mplier_out(mp[i+1]),
         .acc_out(ac[i+1]));
   end

   assign prod = ac[ran_pkg::NCELL];
endmodule

/* rtl/core/ran_divider.sv */
// Restoring divider, one quotient bit a cycle while busy.
// Depends on ran_pkg.
module ran_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ran_pkg::div_ctl_type ctl,
   output ran_pkg::div_res_type res
);
   logic [ran_pkg::PW-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]             cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic [ran_pkg::PW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (ctl.start) begin
         q_in = ctl.dividend; r_in = '0; d_in = ctl.divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[ran_pkg::PW-1]} - {1'b0, d_ff};
         if (!trial[ran_pkg::PW]) begin
            r_in = trial[ran_pkg::PW-1:0];
            q_in = {q_ff[ran_pkg::PW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[ran_pkg::PW-2:0], q_ff[ran_pkg::PW-1]};
            q_in = {q_ff[ran_pkg::PW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = q_ff;
   assign res.remainder = r_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !ctl.start |=> !busy_ff) else $error("divider woke itself");
endmodule

/* rtl/core/rational_add_normalize.sv */
// Top level of the rational adder: sequencer, multiplier chain and shared divider.
// Depends on ran_pkg, ran_mul_chain and ran_divider.
//
//   channel  ports                         direction  handshake
//   request  start, busy, req_data         in         start && !busy
//   result   rsp_valid, rsp_data           out        one-cycle strobe
//
// An item takes a variable number of cycles: three products pass in turn through the
// eight-cell multiplier chain and one state forms the sum. Then comes a Euclidean GCD in
// which every step is a start state and a pass of the shared restoring divider. Two more
// divisions follow, of the numerator and the denominator by the GCD. The number of GCD
// steps sets the length. A zero denominator skips straight to the result.
// busy is high from the accepting edge until the result strobe. Reset is synchronous
// and returns the sequencer to idle. The receiver cannot stall: the result is shown once.
module rational_add_normalize (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ran_pkg::req_type req_data,
   output logic             rsp_valid,
   output ran_pkg::rsp_type rsp_data
);
   localparam int PW = ran_pkg::PW;

   ran_pkg::state_type state_ff, state_in;
   ran_pkg::div_ctl_type dctl;
   ran_pkg::div_res_type dres;

   // Magnitudes and sign bits of the operands, captured on acceptance.
   logic [31:0]   man_ff, mad_ff, mbn_ff, mbd_ff;
   logic          sa_ff, sb_ff, nz_ff, zden_ff;
   logic [PW-1:0] p_ff, q_ff, d_ff, nm_ff, gx_ff, gy_ff, g_ff;
   logic          neg_ff, eq_ff, lt_ff;
   logic [3:0]    cnt_ff;
   logic [1:0]    sel_ff;   // which product is in the chain
   logic [31:0]   mx, my;
   logic [PW-1:0] prod;
   logic          rsp_valid_ff;
   ran_pkg::rsp_type rsp_ff;

   // Sign extension from WIDTH bits, then magnitude.
   function automatic logic [32:0] ext_mag(input logic [31:0] v);
      logic [31:0] s;
      logic [31:0] m;
      s = 32'($signed(v[ran_pkg::WIDTH-1:0]));
      m = s[31] ? (~s + 32'd1) : s;
      return {s[31], m};
   endfunction

   logic [32:0] ea, eb, ec, ed;
   assign ea = ext_mag(req_data.a_num);
   assign eb = ext_mag(req_data.a_den);
   assign ec = ext_mag(req_data.b_num);
   assign ed = ext_mag(req_data.b_den);

   always_comb begin
      unique case (sel_ff)
         2'd0:    begin mx = man_ff; my = mbd_ff; end
         2'd1:    begin mx = mbn_ff; my = mad_ff; end
         default: begin mx = mad_ff; my = mbd_ff; end
      endcase
   end

   ran_mul_chain u_mul (.clock(clock), .x(mx), .y(my), .prod(prod));
   ran_divider   u_div (.clock(clock), .reset(reset), .ctl(dctl), .res(dres));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ran_pkg::ST_IDLE: if (start && !busy) state_in = ran_pkg::ST_MUL;
         ran_pkg::ST_MUL:
            if (zden_ff) state_in = ran_pkg::ST_DONE;
            else if (sel_ff == 2'd2 && cnt_ff == 4'd10) state_in = ran_pkg::ST_SUM;
         ran_pkg::ST_SUM:       state_in = ran_pkg::ST_GCD_START;
         ran_pkg::ST_GCD_START:
            state_in = (gy_ff == '0) ? ran_pkg::ST_DIVN_START : ran_pkg::ST_GCD;
         ran_pkg::ST_GCD:       if (dres.done) state_in = ran_pkg::ST_GCD_START;
         ran_pkg::ST_DIVN_START: state_in = ran_pkg::ST_DIVN;
         ran_pkg::ST_DIVN:      if (dres.done) state_in = ran_pkg::ST_DIVD_START;
         ran_pkg::ST_DIVD_START: state_in = ran_pkg::ST_DIVD;
         ran_pkg::ST_DIVD:      if (dres.done) state_in = ran_pkg::ST_DONE;
         ran_pkg::ST_DONE:      state_in = ran_pkg::ST_IDLE;
         default:               state_in = ran_pkg::ST_IDLE;
      endcase
   end

   // Divider commands.
   always_comb begin
      dctl = '0;
      unique case (state_ff)
         ran_pkg::ST_GCD_START: begin
            dctl.start = (gy_ff != '0); dctl.dividend = gx_ff; dctl.divisor = gy_ff;
         end
         ran_pkg::ST_DIVN_START: begin
            dctl.start = 1'b1; dctl.dividend = nm_ff; dctl.divisor = g_ff;
         end
         ran_pkg::ST_DIVD_START: begin
            dctl.start = 1'b1; dctl.dividend = d_ff; dctl.divisor = g_ff;
         end
         default: dctl = '0;
      endcase
   end

   logic [PW-1:0] lim;
   logic signed [PW:0] ps, qs;
   logic [PW-1:0] nmr;
   assign lim = (PW'(1) << (ran_pkg::WIDTH - 1)) - PW'(1);
   assign ps  = sa_ff ? -$signed({1'b0, p_ff}) : $signed({1'b0, p_ff});
   assign qs  = sb_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign nmr = dres.quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ran_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ran_pkg::ST_DONE);
      end
      unique case (state_ff)
         ran_pkg::ST_IDLE: begin
            man_ff <= ea[31:0]; mad_ff <= eb[31:0];
            mbn_ff <= ec[31:0]; mbd_ff <= ed[31:0];
            sa_ff  <= ea[32] ^ eb[32];
            sb_ff  <= ec[32] ^ ed[32];
            nz_ff  <= (ea[31:0] != '0);
            zden_ff <= (eb[31:0] == '0) || (ed[31:0] == '0);
            cnt_ff <= '0; sel_ff <= 2'd0;
            eq_ff <= 1'b0; lt_ff <= 1'b0;
         end
         ran_pkg::ST_MUL: begin
            // Each product gets its own slot and is taken from the chain at the end of it.
            if (cnt_ff == 4'd10) begin
               cnt_ff <= '0;
               sel_ff <= sel_ff + 2'd1;
               unique case (sel_ff)
                  2'd0:    p_ff <= prod;
                  2'd1:    q_ff <= prod;
                  default: d_ff <= prod;
               endcase
            end else begin
               cnt_ff <= cnt_ff + 4'd1;
            end
         end
         ran_pkg::ST_SUM: begin
            eq_ff <= (ps == qs);
            lt_ff <= (ps < qs);
            if (sa_ff == sb_ff) begin
               nm_ff <= p_ff + q_ff; neg_ff <= sa_ff && (p_ff + q_ff != '0);
               gx_ff <= p_ff + q_ff;
            end else if (p_ff >= q_ff) begin
               nm_ff <= p_ff - q_ff; neg_ff <= sa_ff && (p_ff != q_ff);
               gx_ff <= p_ff - q_ff;
            end else begin
               nm_ff <= q_ff - p_ff; neg_ff <= sb_ff; gx_ff <= q_ff - p_ff;
            end
            gy_ff <= d_ff;
         end
         ran_pkg::ST_GCD_START:
            if (gy_ff == '0) g_ff <= (gx_ff == '0) ? PW'(1) : gx_ff;
         ran_pkg::ST_GCD:
            if (dres.done) begin
               gx_ff <= gy_ff; gy_ff <= dres.remainder;
            end
         ran_pkg::ST_DIVN: if (dres.done) nm_ff <= nmr;
         ran_pkg::ST_DIVD: if (dres.done) d_ff <= nmr;
         default: ;
      endcase
   end

   // Result assembly in the final state.
   always_ff @(posedge clock) begin
      if (state_ff == ran_pkg::ST_DONE) begin
         rsp_ff.a_nonzero <= nz_ff;
         if (zden_ff) begin
            rsp_ff.sum_num <= '0; rsp_ff.sum_den <= '0;
            rsp_ff.is_equal <= 1'b0; rsp_ff.is_less <= 1'b0;
            rsp_ff.status <= ran_pkg::STATUS_ZDEN;
         end else begin
            rsp_ff.is_equal <= eq_ff; rsp_ff.is_less <= lt_ff;
            if (d_ff > lim || (neg_ff ? nm_ff > lim + PW'(1) : nm_ff > lim)) begin
               rsp_ff.sum_num <= '0; rsp_ff.sum_den <= '0;
               rsp_ff.status <= ran_pkg::STATUS_OVF;
            end else begin
               rsp_ff.sum_num <= neg_ff ? -nm_ff[31:0] : nm_ff[31:0];
               rsp_ff.sum_den <= d_ff[30:0];
               rsp_ff.status <= ran_pkg::STATUS_OK;
            end
         end
      end
   end

   assign busy      = (state_ff != ran_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The result strobe is always raised in the cycle after the final state.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ran_pkg::ST_DONE) else $error("stray result");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy) else $error("idle while presenting result");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ran_pkg::ST_MUL) else $error("transfer lost");
endmodule
